/* rtl/i2c_target_uart_bridge_macros.svh */
// ----------------------------------------------------------------------------
// I2C target / UART bridge assertion macros
// Shared property wrappers; clk and arst_n must be visible at the point of use.
// ----------------------------------------------------------------------------
`ifndef I2C_TARGET_UART_BRIDGE_MACROS_SVH
`define I2C_TARGET_UART_BRIDGE_MACROS_SVH

// same-cycle implication
`define I2CUB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define I2CUB_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/i2cub_pkg.sv */
// ----------------------------------------------------------------------------
// i2cub_pkg
// Shared types, event codes and constants of the I2C target / UART bridge.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2cub_pkg;

	// default store depths
	localparam int RX_DEPTH_DEF  = 25;
	localparam int CMD_DEPTH_DEF = 8;
	// most UART bytes sent on one STOP
	localparam int MAX_SEND      = 8;

	// input event codes
	typedef enum logic [3:0] {
		CMD_UART_BYTE  = 4'd0,
		CMD_READ_ADDR  = 4'd1,
		CMD_READ_ACK   = 4'd2,
		CMD_READ_NACK  = 4'd3,
		CMD_WRITE_ADDR = 4'd4,
		CMD_WRITE_DATA = 4'd5,
		CMD_STOP       = 4'd6,
		CMD_ERROR      = 4'd7,
		CMD_OTHER      = 4'd8
	} cmd_t;

	// input item
	typedef struct packed {
		logic [3:0] cmd;
		logic [7:0] data_byte;
	} in_item_t;

	// result item
	typedef struct packed {
		logic [7:0] bus_byte;
		logic       bus_byte_valid;
		logic       ack_next;
		logic       release_bus;
		logic [7:0] uart_byte;
		logic       uart_valid;
		logic       last;
	} out_item_t;

	// rx store controls
	typedef struct packed {
		logic wr;   // store byte at the internal write index
		logic rd;   // read entry at addr
		logic clr;  // mark entry at addr empty
	} rx_ctl_t;

	// command store controls
	typedef struct packed {
		logic wr;       // store byte at addr
		logic rd;       // read entry at addr
		logic clr_all;  // mark all entries empty
	} cmd_ctl_t;

	// fixed single-item results
	localparam out_item_t RES_ACK = '{
		bus_byte: 8'h00, bus_byte_valid: 1'b0, ack_next: 1'b1, release_bus: 1'b0,
		uart_byte: 8'h00, uart_valid: 1'b0, last: 1'b1};

	localparam out_item_t RES_ERR = '{
		bus_byte: 8'h00, bus_byte_valid: 1'b0, ack_next: 1'b0, release_bus: 1'b1,
		uart_byte: 8'h00, uart_valid: 1'b0, last: 1'b1};

	// read past the end of the rx store
	localparam out_item_t RES_RD_END = '{
		bus_byte: 8'h00, bus_byte_valid: 1'b1, ack_next: 1'b0, release_bus: 1'b0,
		uart_byte: 8'h00, uart_valid: 1'b0, last: 1'b1};

endpackage

/* rtl/i2cub_rx_store.sv */
// ----------------------------------------------------------------------------
// i2cub_rx_store
// UART receive store: synchronous RAM, wrapping write index, per-entry
// valid bits so that an empty entry reads as zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cub_rx_store
	import i2cub_pkg::*;
#(
	parameter int RX_DEPTH = RX_DEPTH_DEF,
	localparam int RX_AW   = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  rx_ctl_t          ctl,
	input  logic [RX_AW-1:0] addr,
	input  logic [7:0]       wdata,
	output logic [7:0]       rdata
);

	logic [7:0]          mem [RX_DEPTH];
	logic [RX_DEPTH-1:0] valid_q;
	logic [RX_AW-1:0]    widx_q;
	logic [7:0]          rdata_q;
	logic                hit_q;

	// RAM array: write at the write index, registered read
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[widx_q] <= wdata;
		end
		if (ctl.rd) begin
			rdata_q <= mem[addr];
		end
	end

	// valid bits, write index, read hit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			widx_q  <= '0;
			hit_q   <= 1'b0;
		end else begin
			if (ctl.wr) begin
				valid_q[widx_q] <= 1'b1;
				widx_q <= (widx_q == RX_AW'(RX_DEPTH - 1)) ? '0 : widx_q + RX_AW'(1);
			end
			if (ctl.clr) begin
				valid_q[addr] <= 1'b0;
			end
			if (ctl.rd) begin
				hit_q <= valid_q[addr];
			end
		end
	end

	// empty entries read as zero
	assign rdata = hit_q ? rdata_q : 8'h00;

endmodule

/* rtl/i2cub_cmd_store.sv */
// ----------------------------------------------------------------------------
// i2cub_cmd_store
// I2C command byte store: synchronous RAM with per-entry valid bits and a
// clear of the whole store at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cub_cmd_store
	import i2cub_pkg::*;
#(
	parameter int CMD_DEPTH = CMD_DEPTH_DEF,
	localparam int CMD_AW   = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_ctl_t          ctl,
	input  logic [CMD_AW-1:0] addr,
	input  logic [7:0]        wdata,
	output logic [7:0]        rdata
);

	logic [7:0]           mem [CMD_DEPTH];
	logic [CMD_DEPTH-1:0] valid_q;
	logic [7:0]           rdata_q;
	logic                 hit_q;

	// RAM array
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[addr] <= wdata;
		end
		if (ctl.rd) begin
			rdata_q <= mem[addr];
		end
	end

	// valid bits and read hit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_q   <= 1'b0;
		end else begin
			if (ctl.clr_all) begin
				valid_q <= '0;
			end else if (ctl.wr) begin
				valid_q[addr] <= 1'b1;
			end
			if (ctl.rd) begin
				hit_q <= valid_q[addr];
			end
		end
	end

	assign rdata = hit_q ? rdata_q : 8'h00;

endmodule

/* rtl/i2cub_seq.sv */
// ----------------------------------------------------------------------------
// i2cub_seq
// Event sequencer: decodes one event at a time, drives both stores, owns the
// shared bus pointer and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cub_seq
	import i2cub_pkg::*;
#(
	parameter int RX_DEPTH  = RX_DEPTH_DEF,
	parameter int CMD_DEPTH = CMD_DEPTH_DEF,
	localparam int RX_AW    = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1,
	localparam int CMD_AW   = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	// input channel
	input  logic              in_valid,
	output logic              in_stall,
	input  in_item_t          in_item,
	// output channel
	output logic              out_valid,
	input  logic              out_stall,
	output out_item_t         out_item,
	// rx store
	output rx_ctl_t           rx_ctl,
	output logic [RX_AW-1:0]  rx_addr,
	output logic [7:0]        rx_wdata,
	input  logic [7:0]        rx_rdata,
	// command store
	output cmd_ctl_t          cmd_ctl,
	output logic [CMD_AW-1:0] cmd_addr,
	output logic [7:0]        cmd_wdata,
	input  logic [7:0]        cmd_rdata
);

	localparam int MAX_D  = (RX_DEPTH > CMD_DEPTH) ? RX_DEPTH : CMD_DEPTH;
	localparam int PW     = $clog2(MAX_D + 1);
	localparam int N_SEND = (CMD_DEPTH < MAX_SEND) ? CMD_DEPTH : MAX_SEND;
	localparam int KW     = (N_SEND > 1) ? $clog2(N_SEND) : 1;

	localparam logic [PW-1:0] RX_LIM  = PW'(RX_DEPTH);
	localparam logic [PW-1:0] RX_LAST = PW'(RX_DEPTH - 1);
	localparam logic [PW-1:0] CMD_LIM = PW'(CMD_DEPTH);
	localparam logic [KW-1:0] K_LAST  = KW'(N_SEND - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RX_WAIT,
		ST_CMD_WAIT,
		ST_RESULT
	} state_t;

	state_t    state_q;
	logic [PW-1:0] bp_q;
	logic [KW-1:0] k_q;
	logic      out_valid_q;
	out_item_t out_q;
	out_item_t res_q;

	logic accept;
	logic slot_free;
	logic k_last;
	logic rx_has;
	logic out_load;

	// handshake decode
	assign accept    = in_valid && (state_q == ST_IDLE);
	assign in_stall  = (state_q != ST_IDLE);
	assign slot_free = !out_valid_q || !out_stall;
	assign k_last    = (k_q == K_LAST);
	assign rx_has    = (bp_q < RX_LIM);
	assign out_load  = slot_free && (state_q inside {ST_RX_WAIT, ST_CMD_WAIT, ST_RESULT});

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// rx store access; an entry is read when its event is accepted and cleared in the rx wait state
	always_comb begin
		rx_ctl.wr  = accept && (in_item.cmd == CMD_UART_BYTE);
		rx_ctl.rd  = accept && ((in_item.cmd == CMD_READ_ADDR) ||
			((in_item.cmd == CMD_READ_ACK) && rx_has));
		rx_ctl.clr = (state_q == ST_RX_WAIT) && slot_free;
		rx_addr    = (accept && (in_item.cmd == CMD_READ_ADDR)) ? '0 : bp_q[RX_AW-1:0];
		rx_wdata   = in_item.data_byte;
	end

	// command store access; STOP streams entries 0 to the send count minus one
	always_comb begin
		cmd_ctl.wr      = accept && (in_item.cmd == CMD_WRITE_DATA) && (bp_q < CMD_LIM);
		cmd_ctl.rd      = (accept && (in_item.cmd == CMD_STOP)) ||
			((state_q == ST_CMD_WAIT) && slot_free && !k_last);
		cmd_ctl.clr_all = (state_q == ST_CMD_WAIT) && slot_free && k_last;
		if (state_q == ST_CMD_WAIT) begin
			cmd_addr = CMD_AW'(k_q) + CMD_AW'(1);
		end else if (accept && (in_item.cmd == CMD_STOP)) begin
			cmd_addr = '0;
		end else begin
			cmd_addr = bp_q[CMD_AW-1:0];
		end
		cmd_wdata = in_item.data_byte;
	end

	// sequencer state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bp_q        <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			res_q       <= '0;
		end else begin
			// output valid: set on a new item, dropped once taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (in_item.cmd)
							CMD_UART_BYTE: begin
								state_q <= ST_IDLE;
							end
							CMD_READ_ADDR: begin
								bp_q    <= '0;
								state_q <= ST_RX_WAIT;
							end
							CMD_READ_ACK: begin
								if (rx_has) begin
									state_q <= ST_RX_WAIT;
								end else begin
									res_q   <= RES_RD_END;
									state_q <= ST_RESULT;
								end
							end
							CMD_WRITE_ADDR: begin
								bp_q    <= '0;
								res_q   <= RES_ACK;
								state_q <= ST_RESULT;
							end
							CMD_WRITE_DATA: begin
								// overflow drops the byte and rewinds
								bp_q    <= (bp_q < CMD_LIM) ? bp_q + PW'(1) : '0;
								res_q   <= RES_ACK;
								state_q <= ST_RESULT;
							end
							CMD_STOP: begin
								bp_q    <= '0;
								k_q     <= '0;
								state_q <= ST_CMD_WAIT;
							end
							CMD_ERROR: begin
								res_q   <= RES_ERR;
								state_q <= ST_RESULT;
							end
							default: begin
								res_q   <= RES_ACK;
								state_q <= ST_RESULT;
							end
						endcase
					end
				end
				ST_RX_WAIT: begin
					if (slot_free) begin
						out_q <= '{bus_byte: rx_rdata, bus_byte_valid: 1'b1,
							ack_next: (bp_q < RX_LAST), release_bus: 1'b0,
							uart_byte: 8'h00, uart_valid: 1'b0, last: 1'b1};
						bp_q        <= bp_q + PW'(1);
						state_q     <= ST_IDLE;
					end
				end
				ST_CMD_WAIT: begin
					if (slot_free) begin
						out_q <= '{bus_byte: 8'h00, bus_byte_valid: 1'b0,
							ack_next: 1'b1, release_bus: 1'b0,
							uart_byte: cmd_rdata, uart_valid: 1'b1, last: k_last};
						if (k_last) begin
							state_q <= ST_IDLE;
						end else begin
							k_q <= k_q + KW'(1);
						end
					end
				end
				ST_RESULT: begin
					if (slot_free) begin
						out_q       <= res_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/i2c_target_uart_bridge.sv */
// ----------------------------------------------------------------------------
// i2c_target_uart_bridge
// Event-level bridge between an I2C target and a UART, built around an rx
// byte RAM and a command byte RAM.
// ----------------------------------------------------------------------------
//  channel | signals                      | moves per transfer
//  --------+------------------------------+-------------------------------
//  in      | in_valid, in_stall, in_item  | one bus / UART event
//  out     | out_valid, out_stall, out_item | one result item
//
//  A UART byte goes to the rx RAM and the next event is taken right after.
//  Every other event stalls the input until its last result is loaded, which
//  output stalls delay; in-range reads start the RAM read at the transfer and load
//  the result in the rx wait state. STOP makes min(CMD_DEPTH, 8) RAM reads,
//  one item each. The sequencer works on one event at a time; the output
//  register holds a finished item while the next event is accepted. Reset
//  clears the valid bits of both RAMs at once; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_target_uart_bridge
	import i2cub_pkg::*;
#(
	parameter int RX_DEPTH  = RX_DEPTH_DEF,
	parameter int CMD_DEPTH = CMD_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);

	localparam int RX_AW  = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
	localparam int CMD_AW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;

	rx_ctl_t           rx_ctl;
	logic [RX_AW-1:0]  rx_addr;
	logic [7:0]        rx_wdata;
	logic [7:0]        rx_rdata;
	cmd_ctl_t          cmd_ctl;
	logic [CMD_AW-1:0] cmd_addr;
	logic [7:0]        cmd_wdata;
	logic [7:0]        cmd_rdata;

	// event sequencer
	i2cub_seq #(
		.RX_DEPTH  (RX_DEPTH),
		.CMD_DEPTH (CMD_DEPTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.rx_ctl    (rx_ctl),
		.rx_addr   (rx_addr),
		.rx_wdata  (rx_wdata),
		.rx_rdata  (rx_rdata),
		.cmd_ctl   (cmd_ctl),
		.cmd_addr  (cmd_addr),
		.cmd_wdata (cmd_wdata),
		.cmd_rdata (cmd_rdata)
	);

	// UART receive RAM
	i2cub_rx_store #(
		.RX_DEPTH (RX_DEPTH)
	) u_rx_store (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (rx_ctl),
		.addr   (rx_addr),
		.wdata  (rx_wdata),
		.rdata  (rx_rdata)
	);

	// I2C command RAM
	i2cub_cmd_store #(
		.CMD_DEPTH (CMD_DEPTH)
	) u_cmd_store (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (cmd_ctl),
		.addr   (cmd_addr),
		.wdata  (cmd_wdata),
		.rdata  (cmd_rdata)
	);

endmodule

/* rtl/i2cub_checker.sv */
// ----------------------------------------------------------------------------
// i2cub_checker
// Port-level checks of the I2C target / UART bridge, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "i2c_target_uart_bridge_macros.svh"

module i2cub_checker
	import i2cub_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input in_item_t  in_item,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_item
);

	// a stalled result holds
	`I2CUB_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "stalled result changed")

	// bus error: release only, single final item
	`I2CUB_ASSERT_IMP(a_release, out_valid && out_item.release_bus, !out_item.ack_next && out_item.last && !out_item.uart_valid && !out_item.bus_byte_valid, "bad bus release item")

	// idle byte fields are zero
	`I2CUB_ASSERT_IMP(a_zero_bytes, out_valid, (out_item.uart_valid || (out_item.uart_byte == 8'h00)) && (out_item.bus_byte_valid || (out_item.bus_byte == 8'h00)), "unused byte field not zero")

	// every event but a UART byte busies the sequencer
	`I2CUB_ASSERT_NXT(a_busy, in_valid && !in_stall && (in_item.cmd != CMD_UART_BYTE), in_stall, "event with results not held off")

endmodule

bind i2c_target_uart_bridge i2cub_checker u_i2cub_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_item   (in_item),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the I2C target / UART bridge. Bus and UART events
// go in over the valid/stall input channel. A behavioral mirror of the rx
// store, the command store and the shared bus pointer predicts the result
// items. A checker compares every output transfer with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import i2cub_pkg::*;

	localparam logic [3:0] CMD_CODE_MAX = 4'hF;   // highest event code on the port
	localparam int HOLD_CYCLES    = 300;          // long receiver hold-off
	localparam int WATCHDOG_LIMIT = 2000;         // cycles without any transfer
	localparam int TAIL_CYCLES    = 30;           // quiet time after the last result
	localparam int PHASE_ITEMS    = 10;           // fewest random events per idling phase

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_item;

	// mirror of the bridge state
	logic [7:0] mirror_rx [RX_DEPTH_DEF];
	logic [7:0] mirror_cmd [CMD_DEPTH_DEF];
	int         mirror_wr_idx;
	int         mirror_ptr;

	out_item_t  pending_results[$];

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int hold_req      = 0;
	int n_sent        = 0;
	int n_errors      = 0;
	int quiet_cycles  = 0;

	i2c_target_uart_bridge i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// expected results of one accepted event, state updated as the bridge does
	function automatic void predict_bridge_results(input in_item_t ev);
		out_item_t r;
		int        n;
		r          = '0;
		r.ack_next = 1'b1;
		r.last     = 1'b1;
		case (ev.cmd)
			CMD_UART_BYTE: begin
				mirror_rx[mirror_wr_idx] = ev.data_byte;
				mirror_wr_idx = (mirror_wr_idx == RX_DEPTH_DEF - 1) ? 0 : mirror_wr_idx + 1;
			end
			CMD_READ_ADDR, CMD_READ_ACK: begin
				if (ev.cmd == CMD_READ_ADDR)
					mirror_ptr = 0;
				r.bus_byte_valid = 1'b1;
				// past the end: zero byte, nothing cleared, pointer parked
				if (mirror_ptr < RX_DEPTH_DEF) begin
					r.bus_byte = mirror_rx[mirror_ptr];
					mirror_rx[mirror_ptr] = 8'h00;
					mirror_ptr++;
				end
				r.ack_next = (mirror_ptr < RX_DEPTH_DEF);
				pending_results.push_back(r);
			end
			CMD_WRITE_ADDR: begin
				mirror_ptr = 0;
				pending_results.push_back(r);
			end
			CMD_WRITE_DATA: begin
				// overflowing byte is dropped and the pointer restarts
				if (mirror_ptr >= CMD_DEPTH_DEF) begin
					mirror_ptr = 0;
				end else begin
					mirror_cmd[mirror_ptr] = ev.data_byte;
					mirror_ptr++;
				end
				pending_results.push_back(r);
			end
			CMD_STOP: begin
				mirror_ptr = 0;
				n = (CMD_DEPTH_DEF < MAX_SEND) ? CMD_DEPTH_DEF : MAX_SEND;
				for (int k = 0; k < n; k++) begin
					r            = '0;
					r.ack_next   = 1'b1;
					r.uart_byte  = mirror_cmd[k];
					r.uart_valid = 1'b1;
					r.last       = (k == n - 1);
					pending_results.push_back(r);
				end
				for (int k = 0; k < CMD_DEPTH_DEF; k++)
					mirror_cmd[k] = 8'h00;
			end
			CMD_ERROR: begin
				r.ack_next    = 1'b0;
				r.release_bus = 1'b1;
				pending_results.push_back(r);
			end
			default: begin
				// read nack, other and unused codes
				pending_results.push_back(r);
			end
		endcase
	endfunction

	// one input transfer; starts and ends at a falling edge
	task automatic send_event(input logic [3:0] code, input logic [7:0] data);
		in_item_t ev;
		ev.cmd       = code;
		ev.data_byte = data;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= ev;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		predict_bridge_results(ev);
		n_sent++;
		@(negedge clk);
	endtask

	// drop valid and wait until every predicted result has been taken
	task automatic wait_drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_idling(input int idle, input int stall);
		send_idle_pct = idle;
		stall_pct     = stall;
	endtask

	// command collection: full store, overflow drop, stop, stop on empty store
	task automatic test_directed_writes();
		send_event(CMD_WRITE_ADDR, 8'h00);
		send_event(CMD_WRITE_DATA, 8'hFF);
		send_event(CMD_WRITE_DATA, 8'h00);
		for (int k = 0; k < 6; k++)
			send_event(CMD_WRITE_DATA, 8'(8'h11 * (k + 1)));
		send_event(CMD_WRITE_DATA, 8'hA5);   // dropped, pointer back to 0
		send_event(CMD_WRITE_DATA, 8'h5A);   // lands in entry 0
		send_event(CMD_STOP, 8'h00);
		send_event(CMD_STOP, 8'hFF);         // store already cleared
		wait_drain();
	endtask

	// uart bytes read back over the bus, then a nack
	task automatic test_directed_reads();
		send_event(CMD_UART_BYTE, 8'h00);
		send_event(CMD_UART_BYTE, 8'hFF);
		send_event(CMD_UART_BYTE, 8'h3C);
		send_event(CMD_READ_ADDR, 8'h00);
		send_event(CMD_READ_ACK, 8'hFF);
		send_event(CMD_READ_ACK, 8'h00);
		send_event(CMD_READ_ACK, 8'h00);     // entry never written: zero
		send_event(CMD_READ_NACK, 8'hFF);
		wait_drain();
	endtask

	// bus error, other event, highest unused code
	task automatic test_directed_misc();
		send_event(CMD_ERROR, 8'hFF);
		send_event(CMD_OTHER, 8'h00);
		send_event(CMD_CODE_MAX, 8'hFF);
		wait_drain();
	endtask

	// wrap of the write index, then a read walk over the whole store and past it
	task automatic test_rx_wrap_and_overrun();
		for (int k = 0; k < RX_DEPTH_DEF + 2; k++)
			send_event(CMD_UART_BYTE, 8'($urandom_range(0, 255)));
		send_event(CMD_READ_ADDR, 8'($urandom_range(0, 255)));
		for (int k = 0; k < RX_DEPTH_DEF + 1; k++)
			send_event(CMD_READ_ACK, 8'($urandom_range(0, 255)));
		send_event(CMD_READ_NACK, 8'($urandom_range(0, 255)));
		wait_drain();
	endtask

	// mostly well-formed bus transactions with random content, some noise
	task automatic test_random_traffic(input int idle, input int stall);
		int start;
		int pick;
		int len;
		set_idling(idle, stall);
		start = n_sent;
		while (n_sent - start < PHASE_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 30) : $urandom_range(1, 6);
				repeat (len)
					send_event(CMD_UART_BYTE, 8'($urandom_range(0, 255)));
			end else if (pick < 55) begin
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(23, 28) : $urandom_range(0, 5);
				send_event(CMD_READ_ADDR, 8'($urandom_range(0, 255)));
				repeat (len)
					send_event(CMD_READ_ACK, 8'($urandom_range(0, 255)));
				send_event(CMD_READ_NACK, 8'($urandom_range(0, 255)));
			end else if (pick < 85) begin
				len = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 8);
				send_event(CMD_WRITE_ADDR, 8'($urandom_range(0, 255)));
				repeat (len)
					send_event(CMD_WRITE_DATA, 8'($urandom_range(0, 255)));
				// now and then a write without its stop
				if ($urandom_range(0, 9) != 0)
					send_event(CMD_STOP, 8'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 3))
					send_event(4'($urandom_range(0, CMD_CODE_MAX)),
						8'($urandom_range(0, 255)));
			end
		end
		wait_drain();
	endtask

	// receiver holds off while events keep coming, so the input side stalls
	task automatic test_backpressure();
		set_idling(0, 0);
		hold_req++;
		send_event(CMD_WRITE_ADDR, 8'($urandom_range(0, 255)));
		for (int k = 0; k < CMD_DEPTH_DEF + 1; k++)
			send_event(CMD_WRITE_DATA, 8'($urandom_range(0, 255)));
		send_event(CMD_STOP, 8'($urandom_range(0, 255)));
		send_event(CMD_READ_ADDR, 8'($urandom_range(0, 255)));
		repeat (3)
			send_event(CMD_READ_ACK, 8'($urandom_range(0, 255)));
		send_event(CMD_ERROR, 8'($urandom_range(0, 255)));
		wait_drain();
	endtask

	// receiver: random stall, or a counted hold-off on request
	initial begin
		int hold_taken;
		int hold_left;
		hold_taken = 0;
		hold_left  = 0;
		out_stall  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != hold_taken) begin
				hold_taken = hold_req;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	function automatic void check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			n_errors++;
		end
	endfunction

	// compare each output transfer with the oldest prediction
	always @(posedge clk) begin : result_check
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, actual %h", $time, out_item);
				n_errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("bus_byte", want.bus_byte, out_item.bus_byte);
				check_field("bus_byte_valid", 8'(want.bus_byte_valid),
					8'(out_item.bus_byte_valid));
				check_field("ack_next", 8'(want.ack_next), 8'(out_item.ack_next));
				check_field("release_bus", 8'(want.release_bus), 8'(out_item.release_bus));
				check_field("uart_byte", want.uart_byte, out_item.uart_byte);
				check_field("uart_valid", 8'(want.uart_valid), 8'(out_item.uart_valid));
				check_field("last", 8'(want.last), 8'(out_item.last));
			end
		end
	end

	// watchdog: too long without any transfer on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// test sequence
	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_item       = '0;
		mirror_wr_idx = 0;
		mirror_ptr    = 0;
		for (int k = 0; k < RX_DEPTH_DEF; k++)
			mirror_rx[k] = 8'h00;
		for (int k = 0; k < CMD_DEPTH_DEF; k++)
			mirror_cmd[k] = 8'h00;
		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_writes();
		test_directed_reads();
		test_directed_misc();
		test_rx_wrap_and_overrun();
		test_random_traffic(0, 0);
		test_random_traffic(64, 0);
		test_random_traffic(0, 64);
		test_random_traffic(32, 32);
		test_backpressure();

		set_idling(0, 0);
		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (n_errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
